[hdl/hpa_pkg.sv]
// ----------------------------------------------------------------------------
// hpa_pkg: shared definitions for the Hough plane accumulator
// Codes, default sizes, fixed-point constants and the CORDIC arc table.
// ----------------------------------------------------------------------------
package hpa_pkg;

	// default sizes
	localparam int MAX_ANGLE_STEPS_DEF = 15;
	localparam int MAX_RHO_STEPS_DEF   = 16;
	localparam int COUNT_WIDTH_DEF     = 16;

	// item kinds (s_tuser)
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// result status (m_tuser)
	localparam logic [1:0] STATUS_COUNTED = 2'd0;
	localparam logic [1:0] STATUS_DROPPED = 2'd1;
	localparam logic [1:0] STATUS_READ    = 2'd2;

	// register indexes
	localparam logic REG_ANGLE_STEPS = 1'b0;
	localparam logic REG_RHO_STEPS   = 1'b1;

	localparam logic [3:0] ANGLE_STEPS_RST = 4'd15;
	localparam logic [4:0] RHO_STEPS_RST   = 5'd16;

	// CORDIC
	localparam int                 CORDIC_STEPS = 16;
	localparam logic signed [33:0] CORDIC_Y0    = 34'sd652032874;
	localparam logic signed [18:0] QUARTER_TURN = 19'sd32768;
	localparam logic signed [18:0] HALF_TURN    = 19'sd65536;
	localparam logic signed [32:0] ONE_Q30      = 33'sd1073741824;

	// rho rounding: half of 5 * 2^42, and floor(x/5) for x < 2^18
	localparam logic [57:0] RHO_HALF  = 58'd5 << 41;
	localparam logic [16:0] RECIP5    = 17'd52429;

	// arc tangent of 2^-i in units where pi = 65536
	function automatic logic signed [18:0] arc_tab(input logic [3:0] i);
		logic signed [18:0] v;
		unique case (i)
			4'd0:  v = 19'sd16384;
			4'd1:  v = 19'sd9672;
			4'd2:  v = 19'sd5110;
			4'd3:  v = 19'sd2594;
			4'd4:  v = 19'sd1302;
			4'd5:  v = 19'sd652;
			4'd6:  v = 19'sd326;
			4'd7:  v = 19'sd163;
			4'd8:  v = 19'sd81;
			4'd9:  v = 19'sd41;
			4'd10: v = 19'sd20;
			4'd11: v = 19'sd10;
			4'd12: v = 19'sd5;
			4'd13: v = 19'sd3;
			4'd14: v = 19'sd1;
			4'd15: v = 19'sd1;
			default: v = 19'sd0;
		endcase
		return v;
	endfunction

endpackage

[hdl/hpa_ram.sv]
// ----------------------------------------------------------------------------
// hpa_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module hpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[hdl/hough_plane_accumulator_top.sv]
// ----------------------------------------------------------------------------
// hough_plane_accumulator_top: 3-D Hough accumulator for planes
// Bins point/normal pairs into (theta, phi, rho) counters; reads bin counts.
// ----------------------------------------------------------------------------
// A push transfer carries a point and its unit normal; the block derives
// theta = acos(ny), phi = acos(nx / max(sin theta, cos theta)) and the plane
// offset rho, quantizes them and bumps a saturating counter in the bin store,
// returning the bin address and its new count (or a dropped status when the
// bin falls outside the grid). A read transfer returns the count of one bin.
// All math runs through one sequencer: separate add/shift step logic serves the
// integer square root (31 steps), the CORDIC arccosine and sine/cosine (16
// steps each) and the restoring divider (30 steps), and one 33x33 multiplier
// serves the squares and the rho dot product. A push passes through the idle
// state, two angle passes, the divide when it is needed, the rho products and
// rounding, binning and the read-modify-write of the store; a read goes from
// idle straight to the store access. s_tready is high only while the sequencer
// is idle. After reset the store, 2*MAX_RHO_STEPS*(MAX_ANGLE_STEPS+1)^2 entries
// (8192 at the defaults), is cleared one entry per cycle, during which no item
// is taken; configuration writes are taken at any time but belong between items.
// ----------------------------------------------------------------------------
module hough_plane_accumulator_top #(
	parameter int MAX_ANGLE_STEPS = hpa_pkg::MAX_ANGLE_STEPS_DEF,
	parameter int MAX_RHO_STEPS   = hpa_pkg::MAX_RHO_STEPS_DEF,
	parameter int COUNT_WIDTH     = hpa_pkg::COUNT_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x[15:0], pos_y[31:16], pos_z[47:32], norm_x[63:48],
	// norm_y[79:64], norm_z[95:80], read_address[108:96], zero fill
	input  logic [111:0] s_tdata,
	input  logic         s_tuser,   // kind
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// bin_address[12:0], bin_count[28:13], zero fill
	output logic [31:0]  m_tdata,
	output logic [1:0]   m_tuser,   // status
	// configuration
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [4:0]   cfg_data
);

	localparam int BIN_DEPTH = 2 * MAX_RHO_STEPS * (MAX_ANGLE_STEPS + 1)
		* (MAX_ANGLE_STEPS + 1);
	localparam int AW = $clog2(BIN_DEPTH);

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_SQ, ST_SQRT, ST_ACOS_INIT, ST_ACOS, ST_SINCOS,
		ST_DIV_SET, ST_DIV, ST_MUL_CX, ST_MUL_CZ, ST_MUL_X, ST_MUL_Y, ST_MUL_Z,
		ST_NUM, ST_RND, ST_QUANT, ST_ADDR, ST_MEM, ST_UPD, ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [3:0] angle_steps_q;
	logic [4:0] rho_steps_q;
	logic [5:0] na;
	logic [6:0] nr;

	// captured item
	logic               kind_q;
	logic signed [15:0] px_q, py_q, pz_q, nx_q;
	logic [12:0]        ra_q;

	// sequencer registers
	logic               phase_q;    // 0 theta pass, 1 phi pass
	logic [4:0]         cnt_q;
	logic signed [32:0] v_q;        // arccosine argument, Q30
	logic [60:0]        n_q;        // square root remainder
	logic [61:0]        res_q;      // square root result
	logic signed [33:0] x_q, y_q;
	logic signed [18:0] z_q;
	logic [16:0]        th_q, ph_q;
	logic signed [33:0] cth_q, sth_q, cph_q, sph_q;
	logic [32:0]        rem_q, d_q;
	logic [29:0]        quo_q;
	logic signed [33:0] cx_q, cz_q;
	logic signed [49:0] acc_q;
	logic signed [57:0] num_q;
	logic               neg_q;
	logic [15:0]        w_q;
	logic signed [16:0] r_q;
	logic [7:0]         t_q, p_q;
	logic signed [23:0] a_q;
	logic               drop_q;
	logic [AW-1:0]      mem_addr_q;
	logic [AW-1:0]      clr_q;

	// result register
	logic        m_tvalid_q;
	logic [1:0]  res_status_q, out_status_q;
	logic [12:0] res_addr_q, out_addr_q;
	logic [15:0] res_count_q, out_count_q;

	// clamp registers into range
	always_comb begin
		if (angle_steps_q == '0) begin
			na = 6'd1;
		end else if (32'(angle_steps_q) > MAX_ANGLE_STEPS) begin
			na = 6'(MAX_ANGLE_STEPS);
		end else begin
			na = 6'(angle_steps_q);
		end
		if (rho_steps_q == '0) begin
			nr = 7'd1;
		end else if (32'(rho_steps_q) > MAX_RHO_STEPS) begin
			nr = 7'(MAX_RHO_STEPS);
		end else begin
			nr = 7'(rho_steps_q);
		end
	end

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	assign prod = mul_a * mul_b;

	always_comb begin
		unique case (state_q)
			ST_SQ:     begin mul_a = v_q;           mul_b = v_q;           end
			ST_MUL_CX: begin mul_a = cph_q[32:0];   mul_b = sth_q[32:0];   end
			ST_MUL_CZ: begin mul_a = sph_q[32:0];   mul_b = sth_q[32:0];   end
			ST_MUL_X:  begin mul_a = cx_q[32:0];    mul_b = 33'(px_q);     end
			ST_MUL_Y:  begin mul_a = cth_q[32:0];   mul_b = 33'(py_q);     end
			ST_MUL_Z:  begin mul_a = cz_q[32:0];    mul_b = 33'(pz_q);     end
			default:   begin mul_a = '0;            mul_b = '0;            end
		endcase
	end

	// square root step
	logic [61:0] sq_bit, sq_trial;
	logic        sq_take;
	logic [60:0] n_n;
	logic [61:0] res_n;
	always_comb begin
		sq_bit   = 62'd1 << (7'd60 - {1'b0, cnt_q, 1'b0});
		sq_trial = res_q + sq_bit;
		sq_take  = {1'b0, n_q} >= sq_trial;
		n_n      = sq_take ? n_q - sq_trial[60:0] : n_q;
		res_n    = sq_take ? (res_q >> 1) + sq_bit : res_q >> 1;
	end

	// CORDIC step: vectoring in ST_ACOS, rotation in ST_SINCOS
	logic signed [33:0] dx, dy, x_n, y_n;
	logic signed [18:0] z_n, tab, z_clamp;
	logic               cw;
	always_comb begin
		dx  = y_q >>> cnt_q[3:0];
		dy  = x_q >>> cnt_q[3:0];
		tab = hpa_pkg::arc_tab(cnt_q[3:0]);
		cw  = (state_q == ST_ACOS) ? !y_q[33] : z_q[18];
		x_n = cw ? x_q + dx : x_q - dx;
		y_n = cw ? y_q - dy : y_q + dy;
		z_n = cw ? z_q + tab : z_q - tab;
		if (z_n < 0) begin
			z_clamp = '0;
		end else if (z_n > hpa_pkg::HALF_TURN) begin
			z_clamp = hpa_pkg::HALF_TURN;
		end else begin
			z_clamp = z_n;
		end
	end

	// divider step and phi argument setup
	logic [33:0]        rem2;
	logic               div_ge;
	logic [29:0]        quo_n;
	logic signed [33:0] dmax;
	logic [16:0]        nx_ext;
	logic [32:0]        magv;
	always_comb begin
		rem2   = {rem_q, 1'b0};
		div_ge = rem2 >= {1'b0, d_q};
		quo_n  = {quo_q[28:0], div_ge};
		dmax   = (sth_q > cth_q) ? sth_q : cth_q;
		nx_ext = nx_q[15] ? 17'(-{nx_q[15], nx_q}) : 17'({nx_q[15], nx_q});
		magv   = {1'b0, nx_ext[15:0], 16'd0};
	end

	// rho rounding and binning
	logic [57:0]        magn, rnd_sum;
	logic [32:0]        qm;
	logic [14:0]        qv;
	logic [23:0]        tm, pm, base;
	logic signed [23:0] a_n;
	logic               drop_n;
	always_comb begin
		magn    = num_q[57] ? 58'(-num_q) : 58'(num_q);
		rnd_sum = magn + hpa_pkg::RHO_HALF;
		qm      = 33'(w_q) * 33'(hpa_pkg::RECIP5);
		qv      = qm[32:18];
		tm      = 24'(th_q) * 24'(na) + 24'd32768;
		pm      = 24'(ph_q) * 24'(na) + 24'd32768;
		base    = (24'(t_q) * 24'(na) + 24'(t_q) + 24'(p_q)) * 24'({nr, 1'b0});
		a_n     = $signed(base + 24'(nr)) + 24'(r_q);
		drop_n  = (t_q > 8'(na)) || (p_q > 8'(na))
			|| (r_q < -$signed(17'(nr))) || (r_q >= $signed(17'(nr)))
			|| (a_n < 0) || (32'(a_n) >= BIN_DEPTH);
	end

	// bin store
	logic                   ram_we;
	logic [AW-1:0]          ram_addr;
	logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;
	logic [COUNT_WIDTH-1:0] cnt_new;
	logic [COUNT_WIDTH+15:0] cnt_ext;
	always_comb begin
		cnt_new  = (ram_rdata == {COUNT_WIDTH{1'b1}}) ? ram_rdata
			: ram_rdata + COUNT_WIDTH'(1);
		cnt_ext  = (kind_q == hpa_pkg::KIND_READ) ? (COUNT_WIDTH + 16)'(ram_rdata)
			: (COUNT_WIDTH + 16)'(cnt_new);
		ram_we    = (state_q == ST_CLEAR)
			|| ((state_q == ST_UPD) && (kind_q == hpa_pkg::KIND_PUSH));
		ram_addr  = (state_q == ST_CLEAR) ? clr_q : mem_addr_q;
		ram_wdata = (state_q == ST_CLEAR) ? '0 : cnt_new;
	end

	hpa_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (BIN_DEPTH)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'd0, out_count_q, out_addr_q};
	assign m_tuser  = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			m_tvalid_q    <= 1'b0;
			angle_steps_q <= hpa_pkg::ANGLE_STEPS_RST;
			rho_steps_q   <= hpa_pkg::RHO_STEPS_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					hpa_pkg::REG_ANGLE_STEPS: angle_steps_q <= cfg_data[3:0];
					hpa_pkg::REG_RHO_STEPS:   rho_steps_q   <= cfg_data;
					default: ;
				endcase
			end
			// ST_OUT drives the valid flag itself
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == BIN_DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= s_tuser;
						px_q    <= s_tdata[15:0];
						py_q    <= s_tdata[31:16];
						pz_q    <= s_tdata[47:32];
						nx_q    <= s_tdata[63:48];
						ra_q    <= s_tdata[108:96];
						phase_q <= 1'b0;
						// saturated norm_y, shifted to Q30
						if ($signed(s_tdata[79:64]) > 16'sd16384) begin
							v_q <= hpa_pkg::ONE_Q30;
						end else if ($signed(s_tdata[79:64]) < -16'sd16384) begin
							v_q <= -hpa_pkg::ONE_Q30;
						end else begin
							v_q <= {s_tdata[79], s_tdata[79:64], 16'd0};
						end
						if (s_tuser == hpa_pkg::KIND_READ) begin
							mem_addr_q <= AW'(s_tdata[108:96]);
							state_q    <= ST_MEM;
						end else begin
							state_q <= ST_SQ;
						end
					end
				end
				ST_SQ: begin
					n_q     <= (61'd1 << 60) - prod[60:0];
					res_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					n_q   <= n_n;
					res_q <= res_n;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) begin
						state_q <= ST_ACOS_INIT;
					end
				end
				ST_ACOS_INIT: begin
					// negative argument: turn the vector by a quarter first
					if (v_q < 0) begin
						x_q <= $signed(res_q[33:0]);
						y_q <= -34'(v_q);
						z_q <= hpa_pkg::QUARTER_TURN;
					end else begin
						x_q <= 34'(v_q);
						y_q <= $signed(res_q[33:0]);
						z_q <= '0;
					end
					cnt_q   <= '0;
					state_q <= ST_ACOS;
				end
				ST_ACOS: begin
					if (cnt_q == 5'(hpa_pkg::CORDIC_STEPS - 1)) begin
						if (phase_q) begin
							ph_q <= z_clamp[16:0];
						end else begin
							th_q <= z_clamp[16:0];
						end
						x_q     <= '0;
						y_q     <= hpa_pkg::CORDIC_Y0;
						z_q     <= z_clamp - hpa_pkg::QUARTER_TURN;
						cnt_q   <= '0;
						state_q <= ST_SINCOS;
					end else begin
						x_q   <= x_n;
						y_q   <= y_n;
						z_q   <= z_n;
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_SINCOS: begin
					x_q   <= x_n;
					y_q   <= y_n;
					z_q   <= z_n;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(hpa_pkg::CORDIC_STEPS - 1)) begin
						if (phase_q) begin
							cph_q   <= x_n;
							sph_q   <= y_n;
							state_q <= ST_MUL_CX;
						end else begin
							cth_q   <= x_n;
							sth_q   <= y_n;
							state_q <= ST_DIV_SET;
						end
					end
				end
				ST_DIV_SET: begin
					phase_q <= 1'b1;
					if (dmax <= 0) begin
						// non-positive denominator: argument follows the sign of nx
						if (nx_q > 0) begin
							v_q <= hpa_pkg::ONE_Q30;
						end else if (nx_q < 0) begin
							v_q <= -hpa_pkg::ONE_Q30;
						end else begin
							v_q <= '0;
						end
						state_q <= ST_SQ;
					end else if ({1'b0, magv} >= dmax[33:0]) begin
						v_q     <= nx_q[15] ? -hpa_pkg::ONE_Q30 : hpa_pkg::ONE_Q30;
						state_q <= ST_SQ;
					end else begin
						rem_q   <= magv;
						d_q     <= dmax[32:0];
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= div_ge ? 33'(rem2 - {1'b0, d_q}) : rem2[32:0];
					quo_q <= quo_n;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd29) begin
						v_q     <= nx_q[15] ? -$signed({3'd0, quo_n}) : $signed({3'd0, quo_n});
						state_q <= ST_SQ;
					end
				end
				ST_MUL_CX: begin
					cx_q    <= 34'(prod >>> 30);
					state_q <= ST_MUL_CZ;
				end
				ST_MUL_CZ: begin
					cz_q    <= -34'(prod >>> 30);
					state_q <= ST_MUL_X;
				end
				ST_MUL_X: begin
					acc_q   <= prod[49:0];
					state_q <= ST_MUL_Y;
				end
				ST_MUL_Y: begin
					acc_q   <= acc_q + $signed(prod[49:0]);
					state_q <= ST_MUL_Z;
				end
				ST_MUL_Z: begin
					acc_q   <= acc_q + $signed(prod[49:0]);
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					num_q   <= acc_q * $signed({1'b0, nr});
					state_q <= ST_RND;
				end
				ST_RND: begin
					neg_q   <= num_q[57];
					w_q     <= rnd_sum[57:42];
					state_q <= ST_QUANT;
				end
				ST_QUANT: begin
					r_q     <= neg_q ? -$signed({2'd0, qv}) : $signed({2'd0, qv});
					t_q     <= tm[23:16];
					p_q     <= pm[23:16];
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					a_q        <= a_n;
					drop_q     <= drop_n;
					mem_addr_q <= AW'(a_n);
					state_q    <= ST_MEM;
				end
				ST_MEM: begin
					// read issued this cycle; data arrives next cycle
					if (kind_q == hpa_pkg::KIND_READ) begin
						res_status_q <= hpa_pkg::STATUS_READ;
						res_addr_q   <= ra_q;
						if (32'(ra_q) >= BIN_DEPTH) begin
							res_count_q <= '0;
							state_q     <= ST_OUT;
						end else begin
							state_q <= ST_UPD;
						end
					end else if (drop_q) begin
						res_status_q <= hpa_pkg::STATUS_DROPPED;
						res_addr_q   <= '0;
						res_count_q  <= '0;
						state_q      <= ST_OUT;
					end else begin
						res_status_q <= hpa_pkg::STATUS_COUNTED;
						res_addr_q   <= a_q[12:0];
						state_q      <= ST_UPD;
					end
				end
				ST_UPD: begin
					res_count_q <= cnt_ext[15:0];
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q   <= 1'b1;
						out_status_q <= res_status_q;
						out_addr_q   <= res_addr_q;
						out_count_q  <= res_count_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// an accepted item keeps the sequencer busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while sequencer busy");

	// a counted bin always shows a nonzero count
	a_counted_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == hpa_pkg::STATUS_COUNTED)) |-> (m_tdata[28:13] != '0))
		else $error("counted bin shows zero");

	// a dropped point carries neither address nor count
	a_dropped_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == hpa_pkg::STATUS_DROPPED)) |-> (m_tdata[28:0] == '0))
		else $error("dropped result carries data");

	// the store is written only by the clear pass or a push update
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == ST_CLEAR) || (kind_q == hpa_pkg::KIND_PUSH)))
		else $error("store written outside clear or push update");

endmodule

[tb/sv/hpa_checker.sv]
// ----------------------------------------------------------------------------
// hpa_checker: result predictor and scoreboard for the Hough plane accumulator
// Watches input, result and configuration traffic, models the bin store in
// fixed point and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module hpa_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [31:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [4:0]   cfg_data,
	output int           fail_count,
	output int           pending,
	output int           n_counted,
	output int           n_dropped,
	output int           n_read,
	output int           n_saturated
);

	localparam int BIN_DEPTH = 2 * hpa_pkg::MAX_RHO_STEPS_DEF
		* (hpa_pkg::MAX_ANGLE_STEPS_DEF + 1) ** 2;

	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] addr;
		logic [15:0] count;
	} bin_result_t;

	logic [15:0] bin_store [BIN_DEPTH];
	logic [3:0]  angle_cfg;
	logic [4:0]  rho_cfg;
	bin_result_t expected_results[$];

	// arithmetic shift right with floor
	function automatic longint fsar(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else
				res >>= 1;
			bit_v >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint arc(int i);
		longint t[16] = '{16384, 9672, 5110, 2594, 1302, 652, 326, 163,
			81, 41, 20, 10, 5, 3, 1, 1};
		return t[i];
	endfunction

	// vectoring CORDIC, angle units with pi = 65536
	function automatic longint arccos_units(longint v);
		longint unsigned m;
		longint x, y, z, tmp, dx, dy;
		m = (v < 0) ? -v : v;
		x = v;
		y = int_sqrt((64'd1 << 60) - m * m);
		z = 0;
		if (x < 0) begin
			tmp = x; x = y; y = -tmp; z = 32768;
		end
		for (int i = 0; i < 16; i++) begin
			dx = fsar(y, i); dy = fsar(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += arc(i);
			end else begin
				x -= dx; y += dy; z -= arc(i);
			end
		end
		if (z < 0) z = 0;
		if (z > 65536) z = 65536;
		return z;
	endfunction

	task automatic rotate_sincos(input longint u, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = 0; y = 652032874; z = u - 32768;
		for (int i = 0; i < 16; i++) begin
			dx = fsar(y, i); dy = fsar(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc(i);
			end else begin
				x += dx; y -= dy; z += arc(i);
			end
		end
		c = x; s = y;
	endtask

	task automatic bin_point(input logic [111:0] d, input logic kind, output bin_result_t res);
		longint na, nr, px, py, pz, nx, ny, th, ph, cth, sth, cph, sph, dn, arg, cx, cz;
		longint sm, t, p, r, addr, mm;
		longint unsigned mg, amag, dd;
		logic signed [127:0] num;
		na = (angle_cfg < 1) ? 1 : angle_cfg;
		nr = (rho_cfg < 1) ? 1 : (rho_cfg > hpa_pkg::MAX_RHO_STEPS_DEF
			? hpa_pkg::MAX_RHO_STEPS_DEF : rho_cfg);
		if (kind == hpa_pkg::KIND_READ) begin
			res.status = hpa_pkg::STATUS_READ;
			res.addr = d[108:96];
			res.count = (d[108:96] < BIN_DEPTH) ? bin_store[d[108:96]] : 16'd0;
			return;
		end
		px = longint'($signed(d[15:0])); py = longint'($signed(d[31:16]));
		pz = longint'($signed(d[47:32])); nx = longint'($signed(d[63:48]));
		ny = longint'($signed(d[79:64]));
		if (ny > 16384) ny = 16384;
		if (ny < -16384) ny = -16384;
		th = arccos_units(ny * 65536);
		rotate_sincos(th, cth, sth);
		dn = (sth > cth) ? sth : cth;
		mg = longint'((nx < 0) ? -nx : nx) << 16;
		if (dn <= 0)
			arg = (nx > 0) ? (64'sd1 << 30) : ((nx < 0) ? -(64'sd1 << 30) : 0);
		else begin
			mm = (mg >= dn) ? (64'sd1 << 30) : longint'((mg << 30) / longint'(dn));
			arg = (nx < 0) ? -mm : mm;
		end
		ph = arccos_units(arg);
		rotate_sincos(ph, cph, sph);
		cx = fsar(cph * sth, 30);
		cz = -fsar(sph * sth, 30);
		sm = cx * px + cth * py + cz * pz;
		num = 128'(sm) * 128'(nr);
		dd = 64'd5 << 42;
		amag = (num < 0) ? 64'(-num) : 64'(num);
		r = longint'((2 * amag + dd) / (2 * dd));
		if (num < 0) r = -r;
		t = (th * na + 32768) >>> 16;
		p = (ph * na + 32768) >>> 16;
		addr = (t * (na + 1) + p) * 2 * nr + r + nr;
		if (t > na || p > na || r < -nr || r >= nr || addr < 0 || addr >= BIN_DEPTH) begin
			res = '{hpa_pkg::STATUS_DROPPED, 13'd0, 16'd0};
			return;
		end
		if (bin_store[addr] != 16'hFFFF) bin_store[addr]++;
		else n_saturated++;
		res = '{hpa_pkg::STATUS_COUNTED, 13'(addr), bin_store[addr]};
	endtask

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		bin_result_t r, got;
		if (!arst_n) begin
			for (int i = 0; i < BIN_DEPTH; i++) bin_store[i] = '0;
			angle_cfg = hpa_pkg::ANGLE_STEPS_RST;
			rho_cfg = hpa_pkg::RHO_STEPS_RST;
			expected_results.delete();
			fail_count = 0;
			n_counted = 0; n_dropped = 0; n_read = 0; n_saturated = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[12:0], m_tdata[28:13]};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					fail_count++;
				end else begin
					r = expected_results.pop_front();
					if (got.status != r.status || got.addr != r.addr || got.count != r.count) begin
						$display("%0t: mismatch expected %p actual %p", $time, r, got);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				bin_point(s_tdata, s_tuser, r);
				case (r.status)
					hpa_pkg::STATUS_COUNTED: n_counted++;
					hpa_pkg::STATUS_DROPPED: n_dropped++;
					default:                 n_read++;
				endcase
				expected_results = {expected_results, r};
			end
			if (cfg_we) begin
				if (cfg_index == hpa_pkg::REG_ANGLE_STEPS) angle_cfg = cfg_data[3:0];
				else rho_cfg = cfg_data;
			end
		end
	end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: Hough plane accumulator top-level test
// Drives push and read transfers through several angle/rho settings with
// random idling on both sides; hpa_checker predicts and scores the results.
// ----------------------------------------------------------------------------
module testbench;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid, s_tready, s_tuser;
	logic [111:0] s_tdata;
	logic         m_tvalid, m_tready;
	logic [31:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_we, cfg_index;
	logic [4:0]   cfg_data;
	int           fail_count, pending, n_counted, n_dropped, n_read, n_saturated;
	bit           idle_on;    // random gaps allowed
	bit           hold_sink;  // long receiver hold-off

	hough_plane_accumulator_top dut (.*);

	hpa_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// limit: the clear pass plus every item and its gaps, taken many times over
	initial begin
		#4000000;
		$display("testbench failed");
		$finish;
	end

	// receiver: random stall bursts, or a long hold-off on request
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_tready <= 0;
				repeat (2000) @(posedge clk);
				hold_sink = 0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 16);
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end else begin
				m_tready <= 1;
				@(posedge clk);
			end
		end
	end

	// one input transfer, with an optional gap first; valid stays up after
	// the transfer until the next item or drain() takes it down
	task automatic send_item(input logic kind, input logic [111:0] d);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= kind;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [111:0] pack_push(logic [15:0] px, py, pz, nx, ny, nz);
		return {3'b0, 13'd0, nz, ny, nx, pz, py, px};
	endfunction

	function automatic logic [111:0] pack_read(logic [12:0] a);
		return {3'b0, a, 96'(0)} | 112'($urandom) << 32;
	endfunction

	// random push: mostly true unit normals near the origin so bins land in range
	task automatic send_random_push();
		real a, b, nxr, nyr, nzr;
		logic [15:0] px, py, pz;
		a = $urandom_range(0, 62831) / 10000.0;
		b = $urandom_range(0, 31415) / 10000.0;
		nxr = $sin(b) * $cos(a); nyr = $cos(b); nzr = $sin(b) * $sin(a);
		if ($urandom_range(0, 4) == 0) begin
			px = 16'($urandom); py = 16'($urandom); pz = 16'($urandom);
		end else begin
			px = 16'($signed($urandom_range(0, 24000)) - 12000);
			py = 16'($signed($urandom_range(0, 24000)) - 12000);
			pz = 16'($signed($urandom_range(0, 24000)) - 12000);
		end
		if ($urandom_range(0, 7) == 0)
			send_item(hpa_pkg::KIND_PUSH, pack_push(px, py, pz, 16'($urandom),
				16'($urandom), 16'($urandom)));
		else
			send_item(hpa_pkg::KIND_PUSH, pack_push(px, py, pz, 16'($rtoi(nxr * 16384.0)),
				16'($rtoi(nyr * 16384.0)), 16'($rtoi(nzr * 16384.0))));
	endtask

	task automatic write_reg(input logic idx, input logic [4:0] v);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// stop offering and wait until every expected result has come back
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [4:0] a_set[5] = '{5'd15, 5'd1, 5'd0, 5'd7, 5'd15};
		logic [4:0] r_set[5] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd9};
		arst_n = 0;
		s_tvalid = 0; s_tuser = 0; s_tdata = '0;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		idle_on = 0; hold_sink = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, zero normal, axis normals, reads at store edges and two patterned addresses
		send_item(hpa_pkg::KIND_PUSH, pack_push(16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'd16384, 16'd0, 16'd0));
		send_item(hpa_pkg::KIND_PUSH, pack_push(16'h8000, 16'h8000, 16'h8000,
			-16'sd16384, 16'd0, 16'd0));
		send_item(hpa_pkg::KIND_PUSH, pack_push(16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0));
		send_item(hpa_pkg::KIND_PUSH, pack_push(16'd0, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0));
		send_item(hpa_pkg::KIND_PUSH, pack_push(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		send_item(hpa_pkg::KIND_PUSH, pack_push(16'd0, 16'd0, 16'd0,
			16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_item(hpa_pkg::KIND_PUSH, pack_push(16'd0, 16'd0, 16'd0,
			16'h8000, 16'h8000, 16'h8000));
		send_item(hpa_pkg::KIND_PUSH, pack_push(16'd100, 16'd200, 16'd300,
			16'd11585, 16'd0, 16'd11585));
		send_item(hpa_pkg::KIND_PUSH, pack_push(16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(hpa_pkg::KIND_READ, pack_read(13'd0));
		send_item(hpa_pkg::KIND_READ, pack_read(13'd8191));
		send_item(hpa_pkg::KIND_READ, pack_read(13'h1555));
		send_item(hpa_pkg::KIND_READ, pack_read(13'h0AAA));
		// same bin several times: count climbs
		repeat (5) send_item(hpa_pkg::KIND_PUSH, pack_push(16'd0, 16'd0, 16'd0,
			16'd0, 16'd16384, 16'd0));
		drain();

		// random phases under several register settings, extremes included
		idle_on = 1;
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(hpa_pkg::REG_ANGLE_STEPS, a_set[ph]);
			write_reg(hpa_pkg::REG_RHO_STEPS, r_set[ph]);
			if (ph == 4) idle_on = 0;
			for (int k = 0; k < 170; k++) begin
				if (ph == 1 && k == 20) hold_sink = 1;
				if ($urandom_range(0, 4) == 0)
					send_item(hpa_pkg::KIND_READ, pack_read(13'($urandom_range(0, 8191))));
				else
					send_random_push();
			end
			drain();
		end
		repeat (200) @(posedge clk);

		$display("covered %0d counted, %0d dropped, %0d reads, %0d saturated hits",
			n_counted, n_dropped, n_read, n_saturated);
		$display("five angle/rho settings incl. zero and overrange registers");
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

[files.f]
hdl/hpa_pkg.sv
hdl/hpa_ram.sv
hdl/hough_plane_accumulator_top.sv
tb/sv/hpa_checker.sv
tb/sv/testbench.sv
